>>> rtl/text_console_cell_engine_core_macros.svh
// Assertion macros for the text console cell engine.
// Expects clk and rst_n in the scope of each use.
`ifndef TEXT_CONSOLE_CELL_ENGINE_CORE_MACROS_SVH
`define TEXT_CONSOLE_CELL_ENGINE_CORE_MACROS_SVH

// condition holds at every edge out of reset
`define TCCE_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define TCCE_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define TCCE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/tcce_pkg.sv
// Shared types and constants of the text console cell engine.
// No dependencies; imported by the controller, datapath and top level.
package tcce_pkg;

  localparam int IN_DATA_W  = 40;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;
  localparam int CELL_W     = 15;

  typedef enum logic [2:0] {
    ACT_PUTC        = 3'd0,
    ACT_SET_CURSOR  = 3'd1,
    ACT_CLEAR       = 3'd2,
    ACT_SCROLL_UP   = 3'd3,
    ACT_SCROLL_DOWN = 3'd4,
    ACT_READ_CELL   = 3'd5
  } act_t;

  localparam logic [CFG_IDX_W-1:0] REG_LEFT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOP    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCROLL = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FORE   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BACK   = 3'd6;

  localparam logic [7:0] CH_BS    = 8'd8;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;

  localparam logic [6:0] RST_LEFT   = 7'd0;
  localparam logic [5:0] RST_TOP    = 6'd0;
  localparam logic [7:0] RST_COLS   = 8'd128;
  localparam logic [6:0] RST_ROWS   = 7'd64;
  localparam logic       RST_SCROLL = 1'b1;
  localparam logic [3:0] RST_FORE   = 4'd7;
  localparam logic [3:0] RST_BACK   = 4'd0;

  typedef struct packed {
    logic init_step;
    logic accept;
    logic exec;
    logic rd_cap;
    logic scr_wr;
    logic clr_wr;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic init_done;
    logic to_scroll;
    logic loop_done;
    act_t act;
  } dp_sts_t;

endpackage

>>> rtl/tcce_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tcce_ram #(
  parameter int WIDTH = 15,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

>>> rtl/tcce_ctrl.sv
// Sequencer of the text console cell engine: clearing pass, action steps, output hold.
// Depends on tcce_pkg.
module tcce_ctrl
  import tcce_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  output logic    in_tready,
  output logic    out_tvalid,
  input  logic    out_tready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  typedef enum logic [7:0] {
    ST_INIT   = 8'b0000_0001,
    ST_IDLE   = 8'b0000_0010,
    ST_EXEC   = 8'b0000_0100,
    ST_RDW    = 8'b0000_1000,
    ST_SCR_RD = 8'b0001_0000,
    ST_SCR_WR = 8'b0010_0000,
    ST_CLR    = 8'b0100_0000,
    ST_FIN    = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    state_nxt = state_r;
    unique case (state_r)
      ST_INIT: begin
        cmd.init_step = 1'b1;
        if (sts.init_done) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        unique case (sts.act)
          ACT_CLEAR:                      state_nxt = ST_CLR;
          ACT_SCROLL_UP, ACT_SCROLL_DOWN: state_nxt = ST_SCR_RD;
          ACT_READ_CELL:                  state_nxt = ST_RDW;
          default: begin
            if (sts.to_scroll) begin
              state_nxt = ST_SCR_RD;
            end else if (out_free) begin
              cmd.load_out = 1'b1;
              state_nxt    = ST_IDLE;
            end else begin
              state_nxt = ST_FIN;
            end
          end
        endcase
      end
      ST_RDW: begin
        cmd.rd_cap = 1'b1;
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_SCR_RD: state_nxt = ST_SCR_WR;
      ST_SCR_WR: begin
        cmd.scr_wr = 1'b1;
        if (!sts.loop_done) begin
          state_nxt = ST_SCR_RD;
        end else if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_CLR: begin
        cmd.clr_wr = 1'b1;
        if (sts.loop_done) begin
          if (out_free) begin
            cmd.load_out = 1'b1;
            state_nxt    = ST_IDLE;
          end else begin
            state_nxt = ST_FIN;
          end
        end
      end
      ST_FIN: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_INIT;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> rtl/tcce_dp.sv
// Datapath of the text console cell engine: config registers, cursor, cell RAM,
// putc arithmetic, scroll and clear walkers. Depends on tcce_pkg and tcce_ram.
module tcce_dp
  import tcce_pkg::*;
#(
  parameter int COLS     = 128,
  parameter int ROWS     = 64,
  parameter int TAB_STOP = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic [IN_USER_W-1:0]  in_tuser,
  input  dp_cmd_t               cmd,
  output dp_sts_t               sts,
  output logic [OUT_DATA_W-1:0] out_tdata
);

  localparam int XW        = $clog2(COLS + TAB_STOP + 1);
  localparam int YW        = $clog2(ROWS + 1);
  localparam int DEPTH     = ROWS * COLS;
  localparam int AW        = $clog2(DEPTH);
  localparam int TAB_SH    = 16;
  localparam int TAB_RECIP = (2 ** TAB_SH + TAB_STOP - 1) / TAB_STOP;
  localparam int PW        = XW + TAB_SH + 1;

  localparam logic [XW-1:0] X_ONE = XW'(1);
  localparam logic [YW-1:0] Y_ONE = YW'(1);
  localparam logic [XW-1:0] TAB_X = XW'(TAB_STOP);

  function automatic logic [XW-1:0] eff_left_f(logic [6:0] v);
    logic [8:0] v9;
    v9 = {2'b00, v};
    return (v9 < 9'(COLS)) ? XW'(v9) : XW'(COLS - 1);
  endfunction

  function automatic logic [YW-1:0] eff_top_f(logic [5:0] v);
    logic [7:0] v8;
    v8 = {2'b00, v};
    return (v8 < 8'(ROWS)) ? YW'(v8) : YW'(ROWS - 1);
  endfunction

  function automatic logic [8:0] resolve_f(logic signed [7:0] v, logic [8:0] size);
    logic signed [10:0] r;
    logic signed [10:0] sz;
    sz = signed'({2'b00, size});
    r  = (v < 8'sd0) ? sz + 11'(v) : 11'(v);
    if (r < 11'sd0) r = 11'sd0;
    else if (r > sz - 11'sd1) r = sz - 11'sd1;
    return r[8:0];
  endfunction

  function automatic logic [AW-1:0] addr_f(logic [YW-1:0] row, logic [XW-1:0] col);
    return AW'(row * COLS) + AW'(col);
  endfunction

  // config registers
  logic [6:0] left_r;
  logic [5:0] top_r;
  logic [7:0] cols_r;
  logic [6:0] rows_r;
  logic       scroll_en_r;
  logic [3:0] fore_r, back_r;

  // latched input word
  act_t              act_r;
  logic [7:0]        ch_r;
  logic signed [7:0] px_r;
  logic signed [6:0] py_r;
  logic [7:0]        aw_r;
  logic [6:0]        ah_r;

  logic [XW-1:0] cur_col_r, cur_col_nxt;
  logic [YW-1:0] cur_row_r, cur_row_nxt;
  logic [XW-1:0] tabq_r;
  logic [PW-1:0] tab_prod;
  logic [XW-1:0] tab_next;

  logic [XW-1:0] clr_x_r, clr_w_r;
  logic [YW-1:0] clr_y_r, clr_h_r;
  logic [XW-1:0] ck_r;
  logic [YW-1:0] rk_r;
  logic [AW-1:0] init_cnt_r;

  logic [CELL_W-1:0]     res_cell_r, res_cell_nxt;
  logic                  scrolled_r, scrolled_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  logic [XW-1:0] eff_l, eff_w;
  logic [YW-1:0] eff_t, eff_h;
  logic [8:0]    w_req, w_room;
  logic [7:0]    h_req, h_room;
  logic [XW-1:0] x_res;
  logic [YW-1:0] y_res;

  logic [XW-1:0] pc_col;
  logic [YW-1:0] pc_row;
  logic          pc_write, pc_over;
  logic          to_scroll, is_clr, dir_up, col_end, row_end;
  logic [XW-1:0] lim_w, x_left, scr_col;
  logic [YW-1:0] lim_h, y_left, d_row, s_row;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [CELL_W-1:0] ram_wdata, ram_rdata;

  // effective region
  assign eff_l  = eff_left_f(left_r);
  assign eff_t  = eff_top_f(top_r);
  assign w_req  = (cols_r == 8'd0) ? 9'd1 : {1'b0, cols_r};
  assign w_room = 9'(COLS) - 9'(eff_l);
  assign eff_w  = XW'((w_req > w_room) ? w_room : w_req);
  assign h_req  = (rows_r == 7'd0) ? 8'd1 : {1'b0, rows_r};
  assign h_room = 8'(ROWS) - 8'(eff_t);
  assign eff_h  = YW'((h_req > h_room) ? h_room : h_req);

  assign x_res = XW'(resolve_f(px_r, 9'(eff_w)));
  assign y_res = YW'(resolve_f(8'(py_r), 9'(eff_h)));

  // next tab stop
  assign tab_prod = PW'(cur_col_r) * PW'(TAB_RECIP);
  assign tab_next = (tabq_r + X_ONE) * TAB_X;

  always_comb begin
    pc_col   = cur_col_r;
    pc_row   = cur_row_r;
    pc_write = 1'b0;
    priority if (ch_r == CH_BS) begin
      if (cur_col_r > eff_l) begin
        pc_col = cur_col_r - X_ONE;
      end else if (cur_row_r > eff_t) begin
        pc_col = eff_l + eff_w - X_ONE;
        pc_row = cur_row_r - Y_ONE;
      end
    end else if (ch_r == CH_CR) begin
      pc_col = eff_l;
    end else if (ch_r == CH_LF) begin
      pc_col = eff_l;
      pc_row = cur_row_r + Y_ONE;
    end else if (ch_r == CH_TAB) begin
      pc_col = tab_next;
    end else if (!ch_r[7] && ch_r >= CH_SPACE) begin
      pc_write = 1'b1;
      pc_col   = cur_col_r + X_ONE;
    end else begin
      pc_write = 1'b0;
    end
    if (pc_col >= eff_l + eff_w) begin
      pc_col = eff_l;
      pc_row = pc_row + Y_ONE;
    end
    pc_over = (pc_row >= eff_t + eff_h);
    if (pc_over) pc_row = eff_t + eff_h - Y_ONE;
  end

  assign to_scroll = (act_r == ACT_PUTC) && pc_over && scroll_en_r;

  // walkers
  assign is_clr  = (act_r == ACT_CLEAR);
  assign dir_up  = (act_r != ACT_SCROLL_UP);
  assign lim_w   = is_clr ? clr_w_r : eff_w;
  assign lim_h   = is_clr ? clr_h_r : eff_h;
  assign col_end = (ck_r == lim_w - X_ONE);
  assign row_end = (rk_r == lim_h - Y_ONE);
  assign d_row   = dir_up ? eff_t + rk_r : eff_t + eff_h - Y_ONE - rk_r;
  assign s_row   = dir_up ? d_row + Y_ONE : d_row - Y_ONE;
  assign scr_col = eff_l + ck_r;
  assign x_left  = eff_w - x_res;
  assign y_left  = eff_h - y_res;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = init_cnt_r;
    ram_wdata = '0;
    priority if (cmd.init_step) begin
      ram_we = 1'b1;
    end else if (cmd.exec && act_r == ACT_PUTC && pc_write) begin
      ram_we    = 1'b1;
      ram_waddr = addr_f(cur_row_r, cur_col_r);
      ram_wdata = {back_r, fore_r, ch_r[6:0]};
    end else if (cmd.scr_wr) begin
      ram_we    = 1'b1;
      ram_waddr = addr_f(d_row, scr_col);
      ram_wdata = row_end ? '0 : ram_rdata;
    end else if (cmd.clr_wr) begin
      ram_we    = 1'b1;
      ram_waddr = addr_f(eff_t + clr_y_r + rk_r, eff_l + clr_x_r + ck_r);
      ram_wdata = {back_r, fore_r, CH_SPACE[6:0]};
    end else begin
      ram_we = 1'b0;
    end
  end

  always_comb begin
    priority if (cmd.exec) ram_raddr = addr_f(eff_t + y_res, eff_l + x_res);
    else if (row_end) ram_raddr = '0;
    else ram_raddr = addr_f(s_row, scr_col);
  end

  tcce_ram #(
    .WIDTH(CELL_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk    (clk),
    .we     (ram_we),
    .waddr  (ram_waddr),
    .wdata  (ram_wdata),
    .raddr  (ram_raddr),
    .rdata_r(ram_rdata)
  );

  // cursor
  always_comb begin
    cur_col_nxt = cur_col_r;
    cur_row_nxt = cur_row_r;
    if (cfg_we && (cfg_index == REG_LEFT || cfg_index == REG_TOP ||
                   cfg_index == REG_COLS || cfg_index == REG_ROWS)) begin
      cur_col_nxt = eff_left_f((cfg_index == REG_LEFT) ? cfg_wdata[6:0] : left_r);
      cur_row_nxt = eff_top_f((cfg_index == REG_TOP) ? cfg_wdata[5:0] : top_r);
    end else if (cmd.exec && act_r == ACT_PUTC) begin
      cur_col_nxt = pc_col;
      cur_row_nxt = pc_row;
    end else if (cmd.exec && act_r == ACT_SET_CURSOR) begin
      cur_col_nxt = eff_l + x_res;
      cur_row_nxt = eff_t + y_res;
    end
  end

  always_comb begin
    res_cell_nxt = res_cell_r;
    scrolled_nxt = scrolled_r;
    if (cmd.exec) begin
      res_cell_nxt = '0;
      scrolled_nxt = to_scroll || act_r == ACT_SCROLL_UP || act_r == ACT_SCROLL_DOWN;
    end else if (cmd.rd_cap) begin
      res_cell_nxt = ram_rdata;
    end
  end

  always_comb begin
    out_data_nxt        = '0;
    out_data_nxt[6:0]   = 7'(cur_col_nxt - eff_l);
    out_data_nxt[12:7]  = 6'(cur_row_nxt - eff_t);
    out_data_nxt[27:13] = res_cell_nxt;
    out_data_nxt[28]    = scrolled_nxt;
  end

  assign out_tdata = out_data_r;

  assign sts.init_done = (init_cnt_r == AW'(DEPTH - 1));
  assign sts.to_scroll = to_scroll;
  assign sts.loop_done = col_end && row_end;
  assign sts.act       = act_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r      <= RST_LEFT;
      top_r       <= RST_TOP;
      cols_r      <= RST_COLS;
      rows_r      <= RST_ROWS;
      scroll_en_r <= RST_SCROLL;
      fore_r      <= RST_FORE;
      back_r      <= RST_BACK;
      cur_col_r   <= '0;
      cur_row_r   <= '0;
      init_cnt_r  <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_LEFT:   left_r      <= cfg_wdata[6:0];
          REG_TOP:    top_r       <= cfg_wdata[5:0];
          REG_COLS:   cols_r      <= cfg_wdata;
          REG_ROWS:   rows_r      <= cfg_wdata[6:0];
          REG_SCROLL: scroll_en_r <= cfg_wdata[0];
          REG_FORE:   fore_r      <= cfg_wdata[3:0];
          REG_BACK:   back_r      <= cfg_wdata[3:0];
          default: ;
        endcase
      end
      cur_col_r <= cur_col_nxt;
      cur_row_r <= cur_row_nxt;
      if (cmd.init_step) init_cnt_r <= init_cnt_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    tabq_r     <= XW'(tab_prod >> TAB_SH);
    res_cell_r <= res_cell_nxt;
    scrolled_r <= scrolled_nxt;
    if (cmd.load_out) out_data_r <= out_data_nxt;
    if (cmd.accept) begin
      act_r <= act_t'(in_tuser);
      ch_r  <= in_tdata[7:0];
      px_r  <= in_tdata[15:8];
      py_r  <= in_tdata[22:16];
      aw_r  <= in_tdata[30:23];
      ah_r  <= in_tdata[37:31];
    end
    if (cmd.exec) begin
      clr_x_r <= x_res;
      clr_y_r <= y_res;
      clr_w_r <= (aw_r == 8'd0 || {1'b0, aw_r} > 9'(x_left)) ? x_left : XW'(aw_r);
      clr_h_r <= (ah_r == 7'd0 || {1'b0, ah_r} > 8'(y_left)) ? y_left : YW'(ah_r);
      ck_r    <= '0;
      rk_r    <= '0;
    end else if (cmd.scr_wr || cmd.clr_wr) begin
      if (col_end) begin
        ck_r <= '0;
        rk_r <= rk_r + Y_ONE;
      end else begin
        ck_r <= ck_r + X_ONE;
      end
    end
  end

endmodule

>>> rtl/text_console_cell_engine_core.sv
// Top level of the text console cell engine: controller, datapath, checks.
// Depends on tcce_pkg, tcce_ctrl, tcce_dp and the assertion macro header.
//
// Usage:
//   Input words carry one action each (putc, set cursor, clear, scroll up,
//   scroll down, read cell); every word returns exactly one output word with
//   the region-relative cursor, the read cell (zero unless read) and a scroll
//   flag. Config writes go through cfg_we/cfg_index/cfg_wdata, one per cycle;
//   the user must issue them only while the block is idle; the block does not
//   enforce it. A region write homes the cursor. After reset a clearing pass
//   zeroes all ROWS*COLS cells, one cell a cycle; in_tready stays low until it ends.
//   Steps per word, set by the cell RAM walk:
//     putc / set cursor: accept, then execute
//     read cell: accept, execute, then a read-data capture step
//     clear: accept, execute, then one write per cell of the cut rectangle
//     scroll, or putc that scrolls: accept, execute, then a read and a write per cell of the region
//   The output register holds a word while out_tready is low; the next word
//   is accepted meanwhile and completes once the held word is taken.
`include "text_console_cell_engine_core_macros.svh"

module text_console_cell_engine_core
  import tcce_pkg::*;
#(
  parameter int COLS     = 128,
  parameter int ROWS     = 64,
  parameter int TAB_STOP = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // char_code[7:0], pos_col[15:8], pos_row[22:16], area_cols[30:23], area_rows[37:31]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // action[2:0]
  input  logic [IN_USER_W-1:0]  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // cursor_col[6:0], cursor_row[12:7], cell_char[19:13], cell_fore[23:20],
  // cell_back[27:24], did_scroll[28]
  output logic [OUT_DATA_W-1:0] out_tdata
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  tcce_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tcce_dp #(
    .COLS    (COLS),
    .ROWS    (ROWS),
    .TAB_STOP(TAB_STOP)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_tdata (in_tdata),
    .in_tuser (in_tuser),
    .cmd      (cmd),
    .sts      (sts),
    .out_tdata(out_tdata)
  );

  `TCCE_ASSERT_IMPL(a_no_overwrite, cmd.load_out, !out_tvalid || out_tready, "held result overwritten")
  `TCCE_ASSERT_NEXT(a_accept_exec, in_tvalid && in_tready, cmd.exec, "accepted word not executed")
  `TCCE_ASSERT_IMPL(a_init_blocks, cmd.init_step, !in_tready, "input accepted during clearing pass")
  `TCCE_ASSERT_ALWAYS(a_one_writer, $onehot0({cmd.init_step, cmd.exec, cmd.scr_wr, cmd.clr_wr}), "RAM write conflict")

endmodule
